### design/ttcs_pkg.sv
package ttcs_pkg;

	// Tab stops fall on multiples of TAB_WIDTH, which must be a power of two
	localparam int TAB_WIDTH = 8;
	localparam int TAB_SHIFT = $clog2(TAB_WIDTH);

	// Job queue between parser and executor
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Register file
	localparam int PADDR_W = 3;
	localparam logic REG_TEXT_COLUMNS = 1'b0;
	localparam logic REG_TEXT_ROWS    = 1'b1;
	localparam logic [7:0] COLS_RESET = 8'd80;
	localparam logic [6:0] ROWS_RESET = 7'd25;

	// Character codes
	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_H        = 8'h48;
	localparam logic [7:0] CH_J        = 8'h4A;
	localparam logic [7:0] CH_0        = 8'h30;
	localparam logic [7:0] CH_2        = 8'h32;
	localparam logic [7:0] CH_3        = 8'h33;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_BS       = 8'h08;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_FINAL_LO = 8'h40;
	localparam logic [7:0] CH_FINAL_HI = 8'h7E;

	typedef enum logic [2:0] {
		ESC_TEXT,
		ESC_ESC,
		ESC_CSI,
		ESC_CSI_ARG,
		ESC_CSI_SKIP
	} esc_mode_t;

	// JOB_SYNC: byte with no screen effect, only the cursor is clamped to the geometry
	typedef enum logic [2:0] {
		JOB_GLYPH,
		JOB_NEWLINE,
		JOB_RETURN,
		JOB_BACKSPACE,
		JOB_TAB,
		JOB_HOME,
		JOB_CLEAR,
		JOB_SYNC
	} job_op_t;

	typedef struct packed {
		job_op_t    op;
		logic [7:0] ch;
	} job_t;

	typedef enum logic [1:0] {
		CMD_DRAW   = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_SCROLL = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [7:0] cols;
		logic [6:0] rows;
	} geom_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_TAB,
		BK_SCROLL
	} back_state_t;

endpackage

### design/ttcs_if.sv
interface ttcs_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

interface ttcs_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] cell_column;
	logic [6:0] cell_row;
	logic [7:0] glyph_code;
	logic       last_of_run;

	modport source (output valid, output command, output cell_column, output cell_row,
		output glyph_code, output last_of_run, input ready);
	modport sink   (input valid, input command, input cell_column, input cell_row,
		input glyph_code, input last_of_run, output ready);
endinterface

### design/ttcs_front.sv
module ttcs_front
	import ttcs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	ttcs_char_if.sink    char_in,
	input  logic         q_full,
	output logic         push,
	output job_t         push_job
);

	esc_mode_t mode_q;
	esc_mode_t mode_d;
	logic      accept;
	logic      is_final;
	logic      is_arg;

	assign char_in.ready = !q_full;
	assign accept   = char_in.valid && char_in.ready;
	assign is_final = (char_in.char_code >= CH_FINAL_LO) && (char_in.char_code <= CH_FINAL_HI);
	assign is_arg   = (char_in.char_code == CH_0) || (char_in.char_code == CH_2)
		|| (char_in.char_code == CH_3);

	// Parser next state
	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			ESC_TEXT: begin
				if (char_in.char_code == CH_ESC) mode_d = ESC_ESC;
			end
			ESC_ESC: begin
				mode_d = (char_in.char_code == CH_LBRACKET) ? ESC_CSI : ESC_TEXT;
			end
			ESC_CSI, ESC_CSI_ARG: begin
				priority if (char_in.char_code == CH_H || char_in.char_code == CH_J) begin
					mode_d = ESC_TEXT;
				end else if (mode_q == ESC_CSI && is_arg) begin
					mode_d = ESC_CSI_ARG;
				end else begin
					mode_d = (mode_q == ESC_CSI) ? ESC_CSI_SKIP : ESC_TEXT;
				end
			end
			ESC_CSI_SKIP: begin
				if (is_final) mode_d = ESC_TEXT;
			end
			default: mode_d = ESC_TEXT;
		endcase
	end

	// Classification into executor jobs; every byte yields one, since the
	// cursor is clamped to the current geometry on each byte
	always_comb begin
		push_job.op = JOB_SYNC;
		push_job.ch = char_in.char_code;
		unique case (mode_q)
			ESC_TEXT: begin
				priority if (char_in.char_code == CH_ESC) push_job.op = JOB_SYNC;
				else if (char_in.char_code == CH_LF)      push_job.op = JOB_NEWLINE;
				else if (char_in.char_code == CH_CR)      push_job.op = JOB_RETURN;
				else if (char_in.char_code == CH_BS)      push_job.op = JOB_BACKSPACE;
				else if (char_in.char_code == CH_TAB)     push_job.op = JOB_TAB;
				else                                      push_job.op = JOB_GLYPH;
			end
			ESC_CSI, ESC_CSI_ARG: begin
				if (char_in.char_code == CH_H) begin
					push_job.op = JOB_HOME;
				end else if (char_in.char_code == CH_J) begin
					push_job.op = JOB_CLEAR;
				end
			end
			default: push_job.op = JOB_SYNC;
		endcase
	end

	assign push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ESC_TEXT;
		end else if (accept) begin
			mode_q <= mode_d;
		end
	end

endmodule

### design/ttcs_queue.sv
module ttcs_queue
	import ttcs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output job_t head_job
);

	job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_pop;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// Storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_job;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)   wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

### design/ttcs_back.sv
module ttcs_back
	import ttcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  geom_t       geom,
	input  logic        job_valid,
	input  job_t        job,
	output logic        pop,
	ttcs_cmd_if.source  cmd_out
);

	back_state_t state_q;
	back_state_t state_d;

	logic [7:0] cur_col_q;
	logic [6:0] cur_line_q;
	logic [7:0] stop_q;

	logic       out_valid_q;
	cmd_t       out_cmd_q;
	logic [7:0] out_col_q;
	logic [6:0] out_row_q;
	logic [7:0] out_glyph_q;
	logic       out_last_q;

	logic [7:0] cols_eff;
	logic [6:0] rows_eff;
	logic [7:0] col_sat;
	logic [6:0] line_sat;
	logic [8:0] col_inc;
	logic [7:0] line_inc;
	logic [8:0] tab_raw;
	logic [7:0] tab_stop;
	logic       wrap;
	logic       over_bottom;
	logic [7:0] tab_next;
	logic       tab_done;
	logic       can_emit;
	logic       start;

	logic       emit;
	cmd_t       emit_cmd;
	logic [7:0] emit_col;
	logic [6:0] emit_row;
	logic [7:0] emit_glyph;
	logic       emit_last;
	logic       cur_wr;
	logic [7:0] col_d;
	logic [6:0] line_d;
	logic       stop_wr;

	// Geometry, with zero read as one, and cursor saturated to it
	assign cols_eff    = (geom.cols == '0) ? 8'd1 : geom.cols;
	assign rows_eff    = (geom.rows == '0) ? 7'd1 : geom.rows;
	assign col_sat     = (cur_col_q >= cols_eff) ? cols_eff - 8'd1 : cur_col_q;
	assign line_sat    = (cur_line_q >= rows_eff) ? rows_eff - 7'd1 : cur_line_q;
	assign col_inc     = {1'b0, col_sat} + 9'd1;
	assign line_inc    = {1'b0, line_sat} + 8'd1;
	assign wrap        = (col_inc >= {1'b0, cols_eff});
	assign over_bottom = (line_inc >= {1'b0, rows_eff});

	// Next tab stop, clamped to the last column
	assign tab_raw  = (({1'b0, col_sat} >> TAB_SHIFT) + 9'd1) << TAB_SHIFT;
	assign tab_stop = (tab_raw >= {1'b0, cols_eff}) ? cols_eff - 8'd1 : tab_raw[7:0];

	assign tab_next = cur_col_q + 8'd1;
	assign tab_done = (tab_next == stop_q);

	assign can_emit = !out_valid_q || cmd_out.ready;
	assign start    = (state_q == BK_IDLE) && job_valid && can_emit;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (start) begin
					if (job.op == JOB_GLYPH && wrap && over_bottom) begin
						state_d = BK_SCROLL;
					end else if (job.op == JOB_TAB && col_sat < tab_stop
						&& col_inc[7:0] != tab_stop) begin
						state_d = BK_TAB;
					end
				end
			end
			BK_TAB: begin
				if (can_emit && tab_done) state_d = BK_IDLE;
			end
			BK_SCROLL: begin
				if (can_emit) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Command generation and cursor update
	always_comb begin
		pop        = 1'b0;
		emit       = 1'b0;
		emit_cmd   = CMD_DRAW;
		emit_col   = '0;
		emit_row   = '0;
		emit_glyph = '0;
		emit_last  = 1'b1;
		cur_wr     = 1'b0;
		col_d      = col_sat;
		line_d     = line_sat;
		stop_wr    = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (start) begin
					pop    = 1'b1;
					cur_wr = 1'b1;
					unique case (job.op)
						JOB_GLYPH: begin
							emit       = 1'b1;
							emit_col   = col_sat;
							emit_row   = line_sat;
							emit_glyph = job.ch;
							if (wrap) begin
								col_d = '0;
								if (over_bottom) begin
									line_d    = rows_eff - 7'd1;
									emit_last = 1'b0;
								end else begin
									line_d = line_inc[6:0];
								end
							end else begin
								col_d = col_inc[7:0];
							end
						end
						JOB_NEWLINE: begin
							col_d = '0;
							if (over_bottom) begin
								line_d   = rows_eff - 7'd1;
								emit     = 1'b1;
								emit_cmd = CMD_SCROLL;
							end else begin
								line_d = line_inc[6:0];
							end
						end
						JOB_RETURN: begin
							col_d = '0;
						end
						JOB_BACKSPACE: begin
							if (col_sat != '0) begin
								col_d      = col_sat - 8'd1;
								emit       = 1'b1;
								emit_col   = col_sat - 8'd1;
								emit_row   = line_sat;
								emit_glyph = CH_SPACE;
							end else if (line_sat != '0) begin
								col_d      = cols_eff - 8'd1;
								line_d     = line_sat - 7'd1;
								emit       = 1'b1;
								emit_col   = cols_eff - 8'd1;
								emit_row   = line_sat - 7'd1;
								emit_glyph = CH_SPACE;
							end
						end
						JOB_TAB: begin
							stop_wr = 1'b1;
							if (col_sat < tab_stop) begin
								col_d      = col_inc[7:0];
								emit       = 1'b1;
								emit_col   = col_sat;
								emit_row   = line_sat;
								emit_glyph = CH_SPACE;
								emit_last  = (col_inc[7:0] == tab_stop);
							end else begin
								col_d = tab_stop;
							end
						end
						JOB_HOME: begin
							col_d  = '0;
							line_d = '0;
						end
						JOB_CLEAR: begin
							col_d    = '0;
							line_d   = '0;
							emit     = 1'b1;
							emit_cmd = CMD_CLEAR;
						end
						JOB_SYNC: begin
							// cursor only takes the saturated position
							col_d = col_sat;
						end
						default: begin
							col_d = col_sat;
						end
					endcase
				end
			end
			BK_TAB: begin
				// Erase the remaining cells up to the stop, one a cycle while the output can take a command
				if (can_emit) begin
					cur_wr     = 1'b1;
					col_d      = tab_next;
					line_d     = cur_line_q;
					emit       = 1'b1;
					emit_col   = cur_col_q;
					emit_row   = cur_line_q;
					emit_glyph = CH_SPACE;
					emit_last  = tab_done;
				end
			end
			BK_SCROLL: begin
				emit     = can_emit;
				emit_cmd = CMD_SCROLL;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cur_col_q   <= '0;
			cur_line_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cur_wr) begin
				cur_col_q  <= col_d;
				cur_line_q <= line_d;
			end
			if (emit)               out_valid_q <= 1'b1;
			else if (cmd_out.ready) out_valid_q <= 1'b0;
		end
	end

	// Output register and tab stop
	always_ff @(posedge clk) begin
		if (stop_wr) stop_q <= tab_stop;
		if (emit) begin
			out_cmd_q   <= emit_cmd;
			out_col_q   <= emit_col;
			out_row_q   <= emit_row;
			out_glyph_q <= emit_glyph;
			out_last_q  <= emit_last;
		end
	end

	assign cmd_out.valid       = out_valid_q;
	assign cmd_out.command     = out_cmd_q;
	assign cmd_out.cell_column = out_col_q;
	assign cmd_out.cell_row    = out_row_q;
	assign cmd_out.glyph_code  = out_glyph_q;
	assign cmd_out.last_of_run = out_last_q;

endmodule

### design/text_terminal_control_sequencer_core.sv
// Channel   Dir  Handshake           Payload
// char_in   in   valid/ready         char_code[7:0]
// cmd_out   out  valid/ready         command, cell_column, cell_row, glyph_code, last_of_run
// apb       in   psel/penable/pready paddr[2:0], pwdata, prdata (text_columns @0, text_rows @4)
//
// The parser takes one byte a cycle into a 4-entry job queue; ready drops only when it is full.
// The executor takes a new job only when idle: a tab emits one erase command per cell up to its stop,
// a glyph that wraps past the bottom emits its draw and then a scroll, any other job at most one command.
// Reset puts the parser in text mode, the cursor home and the geometry at 80 x 25.
// A held output register stalls the executor only; the parser keeps filling the queue.
module text_terminal_control_sequencer_core
	import ttcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	ttcs_char_if.sink          char_in,
	ttcs_cmd_if.source         cmd_out
);

	geom_t geom_q;
	logic  reg_sel;
	logic  cfg_wr;
	logic  push;
	job_t  push_job;
	logic  q_full;
	logic  head_valid;
	job_t  head_job;
	logic  pop;

	// Register file
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.cols <= COLS_RESET;
			geom_q.rows <= ROWS_RESET;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_TEXT_COLUMNS: geom_q.cols <= pwdata[7:0];
				REG_TEXT_ROWS:    geom_q.rows <= pwdata[6:0];
				default:          geom_q      <= geom_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_TEXT_COLUMNS: prdata = {24'd0, geom_q.cols};
			REG_TEXT_ROWS:    prdata = {25'd0, geom_q.rows};
			default:          prdata = '0;
		endcase
	end

	ttcs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_in  (char_in),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	ttcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	ttcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom_q),
		.job_valid (head_valid),
		.job       (head_job),
		.pop       (pop),
		.cmd_out   (cmd_out)
	);

endmodule
